/* rtl/quoted_command_line_tokenizer_macros.svh */
// Assertion macros for the quoted command line tokenizer.
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_MACROS_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QCLT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define QCLT_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("%m: next-cycle check failed");

`endif

/* rtl/qclt_pkg.sv */
// Package: byte codes, scan state and result types for the tokenizer.
package qclt_pkg;

   localparam int CH_W               = 8;
   localparam int LIMIT_W            = 6;
   localparam int INDEX_W            = 5;
   localparam int COUNT_W            = 6;
   localparam int DEFAULT_MAX_TOKENS = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   localparam logic [CH_W-1:0] CH_EOL    = 8'h00;
   localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
   localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

   typedef enum logic [3:0] {
      MODE_BETWEEN = 4'b0001,
      MODE_PLAIN   = 4'b0010,
      MODE_QUOTED  = 4'b0100,
      MODE_ESCAPE  = 4'b1000
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     quote_single;
      logic     at_line_start;
      logic     comment_line;
      logic     text_seen;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{
      mode:          MODE_BETWEEN,
      quote_single:  1'b0,
      at_line_start: 1'b1,
      comment_line:  1'b0,
      text_seen:     1'b0
   };

   typedef struct packed {
      logic               kept;
      logic               tok_start;
      logic               tok_end;
      logic [INDEX_W-1:0] index;
      logic               done;
      logic [COUNT_W-1:0] count;
      logic               ignored;
   } result_type;

endpackage

/* rtl/qclt_step.sv */
// Per-byte scan logic: next scan state and result marks for one byte.
module qclt_step
   import qclt_pkg::*;
#(
   parameter int MAX_TOKENS = DEFAULT_MAX_TOKENS,
   parameter int CNT_W      = $clog2(MAX_TOKENS + 1)
) (
   input  logic [CH_W-1:0]    ch,
   input  logic [LIMIT_W-1:0] limit,
   input  ctrl_type           ctrl_cur,
   input  logic [CNT_W-1:0]   found_cur,
   output ctrl_type           ctrl_nxt,
   output logic [CNT_W-1:0]   found_nxt,
   output result_type         res
);

   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic [CMP_W-1:0] lim_ext;
   logic [CMP_W-1:0] max_ext;
   logic [CMP_W-1:0] eff_limit;
   logic             below_limit;
   logic             blank;
   logic             quote;
   logic             comment;
   logic [CH_W-1:0]  closer;
   logic [CNT_W-1:0] cur_idx;

   assign lim_ext     = CMP_W'(limit);
   assign max_ext     = CMP_W'(MAX_TOKENS);
   assign eff_limit   = (lim_ext > max_ext) ? max_ext : lim_ext;
   assign below_limit = CMP_W'(found_cur) < eff_limit;
   assign blank       = (ch == CH_SPACE) || (ch == CH_TAB);
   assign quote       = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
   assign comment     = ctrl_cur.comment_line || (ctrl_cur.at_line_start && ch == CH_HASH);
   assign closer      = ctrl_cur.quote_single ? CH_SQUOTE : CH_DQUOTE;

   always_comb begin
      res       = '0;
      ctrl_nxt  = ctrl_cur;
      found_nxt = found_cur;
      cur_idx   = (found_cur != '0) ? found_cur - CNT_W'(1) : '0;

      if (ch == CH_EOL) begin
         res.done    = 1'b1;
         res.count   = COUNT_W'(found_cur);
         res.ignored = ctrl_cur.at_line_start || comment;
         if (ctrl_cur.mode != MODE_BETWEEN) begin
            res.tok_end = 1'b1;
            if (ctrl_cur.mode == MODE_QUOTED && !ctrl_cur.text_seen) begin
               res.tok_start = 1'b1;
            end
         end
         ctrl_nxt  = CTRL_RESET;
         found_nxt = '0;
      end else begin
         ctrl_nxt.at_line_start = 1'b0;
         ctrl_nxt.comment_line  = comment;
         if (comment) begin
            res.ignored = 1'b1;
         end else begin
            case (ctrl_cur.mode)
               MODE_BETWEEN: begin
                  if (!blank && below_limit) begin
                     found_nxt = found_cur + CNT_W'(1);
                     cur_idx   = found_cur;
                     if (quote) begin
                        ctrl_nxt.mode         = MODE_QUOTED;
                        ctrl_nxt.quote_single = (ch == CH_SQUOTE);
                        ctrl_nxt.text_seen    = 1'b0;
                     end else begin
                        ctrl_nxt.mode = MODE_PLAIN;
                        res.kept      = 1'b1;
                        res.tok_start = 1'b1;
                     end
                  end
               end
               MODE_PLAIN: begin
                  if (blank || quote) begin
                     res.tok_end   = 1'b1;
                     ctrl_nxt.mode = MODE_BETWEEN;
                  end else begin
                     res.kept = 1'b1;
                  end
               end
               MODE_QUOTED: begin
                  if (ch == closer) begin
                     res.tok_end   = 1'b1;
                     res.tok_start = !ctrl_cur.text_seen;
                     ctrl_nxt.mode = MODE_BETWEEN;
                  end else begin
                     res.kept           = 1'b1;
                     res.tok_start      = !ctrl_cur.text_seen;
                     ctrl_nxt.text_seen = 1'b1;
                     if (ch == CH_BSLASH) begin
                        ctrl_nxt.mode = MODE_ESCAPE;
                     end
                  end
               end
               MODE_ESCAPE: begin
                  res.kept      = 1'b1;
                  ctrl_nxt.mode = MODE_QUOTED;
               end
               default: begin
                  ctrl_nxt.mode = MODE_BETWEEN;
               end
            endcase
         end
      end

      if (res.kept || res.tok_start || res.tok_end) begin
         res.index = INDEX_W'(cur_idx);
      end
   end

endmodule

/* rtl/quoted_command_line_tokenizer.sv */
// Quoted command line tokenizer: one line byte in, one set of token marks out.
//
// Input channel req_: one byte per transfer (req_ch); byte 0 ends the line.
// Output channel rsp_: one result per byte, in order: text/start/end marks,
// token index, and on the line end the token count and ignored-line flag.
// csr_: csr_wr_data is taken into the token limit whenever csr_wr_en is high;
// write it only while no byte is in flight.
// Pipeline: a byte is held in the input register while it is scanned, and
// its result is loaded into the output register, from which it is offered
// on rsp_. One byte per cycle is sustained while rsp_ready stays high; the
// rate is set by the scan state update, which is done once per byte.
// Reset clears the valid flags of both pipeline registers, returns the
// scanner to the start of a line and sets the token limit to 32.
// When rsp_ready is low the result holds, the input register keeps one more
// byte, and req_ready then drops until the result is taken.
`include "quoted_command_line_tokenizer_macros.svh"

module quoted_command_line_tokenizer
   import qclt_pkg::*;
#(
   parameter int MAX_TOKENS = DEFAULT_MAX_TOKENS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CH_W-1:0]    req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_byte_kept,
   output logic               rsp_token_start,
   output logic               rsp_token_end,
   output logic [INDEX_W-1:0] rsp_token_index,
   output logic               rsp_line_done,
   output logic [COUNT_W-1:0] rsp_token_count,
   output logic               rsp_ignored_line,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_TOKENS + 1);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [CH_W-1:0]    in_ch_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         rsp_res_ff;
   ctrl_type           ctrl_ff;
   ctrl_type           ctrl_in;
   logic [CNT_W-1:0]   found_ff;
   logic [CNT_W-1:0]   found_in;
   logic [LIMIT_W-1:0] limit_ff;
   result_type         step_res;
   logic               out_adv;
   logic               in_adv;
   logic               req_xfer;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign in_adv    = in_valid_ff && out_adv;
   assign req_ready = !in_valid_ff || out_adv;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (in_adv ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = out_adv ? in_valid_ff : rsp_valid_ff;

   qclt_step #(
      .MAX_TOKENS (MAX_TOKENS),
      .CNT_W      (CNT_W)
   ) u_step (
      .ch        (in_ch_ff),
      .limit     (limit_ff),
      .ctrl_cur  (ctrl_ff),
      .found_cur (found_ff),
      .ctrl_nxt  (ctrl_in),
      .found_nxt (found_in),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= CTRL_RESET;
         found_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_adv) begin
            ctrl_ff  <= ctrl_in;
            found_ff <= found_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ch_ff <= req_ch;
      end
      if (in_adv) begin
         rsp_res_ff <= step_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_kept    = rsp_res_ff.kept;
   assign rsp_token_start  = rsp_res_ff.tok_start;
   assign rsp_token_end    = rsp_res_ff.tok_end;
   assign rsp_token_index  = rsp_res_ff.index;
   assign rsp_line_done    = rsp_res_ff.done;
   assign rsp_token_count  = rsp_res_ff.count;
   assign rsp_ignored_line = rsp_res_ff.ignored;

   // line end returns the scanner to the start of a line
   `QCLT_ASSERT_NXT(a_line_restart, clock, reset, in_adv && in_ch_ff == CH_EOL, found_ff == '0 && ctrl_ff.at_line_start && ctrl_ff.mode == MODE_BETWEEN)

   `QCLT_ASSERT_IMP(a_found_bound, clock, reset, 1'b1, found_ff <= CNT_W'(MAX_TOKENS))

   // bytes of an ignored line carry no token marks
   `QCLT_ASSERT_IMP(a_ignored_unmarked, clock, reset, rsp_valid_ff && rsp_res_ff.ignored && !rsp_res_ff.done, !rsp_res_ff.kept && !rsp_res_ff.tok_start && !rsp_res_ff.tok_end)

endmodule
